>>> rtl/core/sacm_pkg.sv
// Shared types and constants for the set-associative cache timing model.
// No dependencies; used by sacm_cfg, sacm_lookup and the top level.
package sacm_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned TAG_W       = 30;
  localparam int unsigned CYC_W       = 16;
  localparam int unsigned APB_AW      = 5;
  localparam int unsigned APB_DW      = 32;

  // Timing model: one memory transfer of a word costs this many cycles.
  localparam logic [CYC_W-1:0] MEM_CYCLES = 16'd100;
  localparam logic [CYC_W-1:0] HIT_CYCLES = 16'd1;
  localparam logic [3:0]       OB_MIN     = 4'd2;
  localparam logic [3:0]       OB_MAX     = 4'd10;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  typedef enum logic [2:0] {
    REG_SETS_LOG2        = 3'd0,
    REG_BLOCK_BYTES_LOG2 = 3'd1,
    REG_USE_FIFO         = 3'd2,
    REG_WRITE_BACK       = 3'd3,
    REG_WRITE_ALLOCATE   = 3'd4
  } reg_e;

  typedef struct packed {
    logic [3:0] sets_log2;
    logic [3:0] block_bytes_log2;
    logic       use_fifo;
    logic       write_back;
    logic       write_allocate;
  } cfg_t;

  typedef struct packed {
    logic             hit;
    logic             dirty_evicted;
    logic [CYC_W-1:0] access_cycles;
  } res_t;

endpackage

>>> rtl/core/sacm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sacm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sacm_cfg.sv
// APB register file holding the cache geometry and policy settings.
// Depends on sacm_pkg for the register indexes and the cfg_t bundle.
module sacm_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sacm_pkg::APB_AW-1:0] paddr,
  input  logic [sacm_pkg::APB_DW-1:0] pwdata,
  output logic [sacm_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output sacm_pkg::cfg_t              cfg_o
);

  sacm_pkg::cfg_t cfg_q, cfg_d;
  sacm_pkg::reg_e reg_sel;
  logic           wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = sacm_pkg::reg_e'(paddr[4:2]);

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    unique case (reg_sel)
      sacm_pkg::REG_SETS_LOG2: begin
        prdata = {28'd0, cfg_q.sets_log2};
        if (wr_en) cfg_d.sets_log2 = pwdata[3:0];
      end
      sacm_pkg::REG_BLOCK_BYTES_LOG2: begin
        prdata = {28'd0, cfg_q.block_bytes_log2};
        if (wr_en) cfg_d.block_bytes_log2 = pwdata[3:0];
      end
      sacm_pkg::REG_USE_FIFO: begin
        prdata = {31'd0, cfg_q.use_fifo};
        if (wr_en) cfg_d.use_fifo = pwdata[0];
      end
      sacm_pkg::REG_WRITE_BACK: begin
        prdata = {31'd0, cfg_q.write_back};
        if (wr_en) cfg_d.write_back = pwdata[0];
      end
      sacm_pkg::REG_WRITE_ALLOCATE: begin
        prdata = {31'd0, cfg_q.write_allocate};
        if (wr_en) cfg_d.write_allocate = pwdata[0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sets_log2        <= 4'd0;
      cfg_q.block_bytes_log2 <= sacm_pkg::OB_MIN;
      cfg_q.use_fifo         <= 1'b0;
      cfg_q.write_back       <= 1'b1;
      cfg_q.write_allocate   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/sacm_lookup.sv
// Address split, tag compare, victim choice and set update for one set row.
// Depends on sacm_pkg; pure combinational, fed by the tag RAM read port.
module sacm_lookup #(
  parameter int unsigned MAX_SETS = 1024,
  parameter int unsigned WAYS     = 4
) (
  input  sacm_pkg::cfg_t                      cfg_i,
  input  logic                                cmd_i,
  input  logic [sacm_pkg::ADDR_W-1:0]         addr_i,
  input  logic [WAYS*(2+sacm_pkg::TAG_W+((WAYS > 1) ? $clog2(WAYS) : 1))-1:0] row_i,
  output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] set_o,
  output logic [WAYS*(2+sacm_pkg::TAG_W+((WAYS > 1) ? $clog2(WAYS) : 1))-1:0] row_o,
  output sacm_pkg::res_t                      res_o
);

  localparam int unsigned RK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WIX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned IDX_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned TAG_W = sacm_pkg::TAG_W;
  localparam int unsigned WAY_W = 2 + TAG_W + RK_W;
  localparam int unsigned MSL   = $clog2(MAX_SETS + 1) - 1;
  localparam logic [RK_W-1:0] RK_MAX   = RK_W'(WAYS - 1);
  localparam logic [RK_W:0]   RK_LIMIT = (RK_W + 1)'(WAYS);

  logic [3:0]                    sl, ob;
  logic [sacm_pkg::ADDR_W-1:0]   shifted, set_mask, tag_full;
  logic [TAG_W-1:0]              tag;
  logic [sacm_pkg::CYC_W-1:0]    block_cost;

  assign sl = (cfg_i.sets_log2 > 4'(MSL)) ? 4'(MSL) : cfg_i.sets_log2;
  assign ob = (cfg_i.block_bytes_log2 < sacm_pkg::OB_MIN) ? sacm_pkg::OB_MIN :
              (cfg_i.block_bytes_log2 > sacm_pkg::OB_MAX) ? sacm_pkg::OB_MAX :
              cfg_i.block_bytes_log2;

  assign shifted    = addr_i >> ob;
  assign set_mask   = (32'd1 << sl) - 32'd1;
  assign set_o      = IDX_W'(shifted & set_mask);
  assign tag_full   = addr_i >> (5'(sl) + 5'(ob));
  assign tag        = tag_full[TAG_W-1:0];
  assign block_cost = sacm_pkg::MEM_CYCLES << (ob - sacm_pkg::OB_MIN);

  always_comb begin
    logic [WAYS-1:0]  v, d, v_n, d_n;
    logic [TAG_W-1:0] tg   [WAYS];
    logic [TAG_W-1:0] tg_n [WAYS];
    logic [RK_W-1:0]  rk   [WAYS];
    logic [RK_W-1:0]  rk_n [WAYS];
    logic             found, any_inv, no_alloc, do_age, is_store, wt_store;
    logic [WIX_W-1:0] hway, iway, oway, tgt;
    logic [RK_W-1:0]  best;
    logic [RK_W:0]    limit;
    logic [sacm_pkg::CYC_W-1:0] cyc;
    logic             dirty_out;

    for (int i = 0; i < WAYS; i++) begin
      {v[i], d[i], tg[i], rk[i]} = row_i[i*WAY_W +: WAY_W];
    end

    is_store = (cmd_i == sacm_pkg::CMD_STORE);
    wt_store = is_store & ~cfg_i.write_back;
    no_alloc = is_store & ~cfg_i.write_allocate & ~cfg_i.write_back;

    // lowest matching way and lowest free way
    found = 1'b0;
    any_inv = 1'b0;
    hway = '0;
    iway = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (v[i] && tg[i] == tag) begin
        found = 1'b1;
        hway  = WIX_W'(i);
      end
      if (!v[i]) begin
        any_inv = 1'b1;
        iway    = WIX_W'(i);
      end
    end

    // oldest way, lowest index on ties
    best = rk[0];
    oway = '0;
    for (int i = 1; i < WAYS; i++) begin
      if (rk[i] > best) begin
        best = rk[i];
        oway = WIX_W'(i);
      end
    end

    tgt       = found ? hway : (any_inv ? iway : oway);
    dirty_out = !found && !no_alloc && !any_inv && d[oway];
    limit     = found ? {1'b0, rk[hway]} : RK_LIMIT;
    do_age    = found ? ~cfg_i.use_fifo : ~no_alloc;

    v_n = v;
    d_n = d;
    for (int i = 0; i < WAYS; i++) begin
      tg_n[i] = tg[i];
      rk_n[i] = rk[i];
      if (do_age && WIX_W'(i) != tgt && v[i] && {1'b0, rk[i]} < limit &&
          rk[i] < RK_MAX) begin
        rk_n[i] = rk[i] + RK_W'(1);
      end
    end

    if (found) begin
      if (is_store && cfg_i.write_back) d_n[tgt] = 1'b1;
      if (!cfg_i.use_fifo) rk_n[tgt] = '0;
      cyc = sacm_pkg::HIT_CYCLES + (wt_store ? sacm_pkg::MEM_CYCLES : '0);
    end else if (no_alloc) begin
      cyc = sacm_pkg::MEM_CYCLES;
    end else begin
      v_n[tgt]  = 1'b1;
      d_n[tgt]  = is_store & cfg_i.write_back;
      tg_n[tgt] = tag;
      rk_n[tgt] = '0;
      cyc = block_cost + sacm_pkg::HIT_CYCLES +
            (dirty_out ? block_cost : '0) +
            (wt_store ? sacm_pkg::MEM_CYCLES : '0);
    end

    for (int i = 0; i < WAYS; i++) begin
      row_o[i*WAY_W +: WAY_W] = {v_n[i], d_n[i], tg_n[i], rk_n[i]};
    end

    res_o.hit           = found;
    res_o.dirty_evicted = dirty_out;
    res_o.access_cycles = cyc;
  end

endmodule

>>> rtl/core/set_assoc_cache_timing_model.sv
// Set-associative cache timing model: one load or store in, one cost result out.
// Each beat passes IDLE (accept), LOOK (tag RAM read) and CALC (read-modify-write of the set
// row through one RAM port pair); the next beat is taken only once the last one leaves CALC.
// Results wait in an output register, so a new beat is accepted while one is pending.
// After reset a clearing pass zeroes all MAX_SETS rows of the tag RAM; no beat is taken
// meanwhile, configuration writes are. Depends on sacm_pkg, sacm_cfg, sacm_lookup, sacm_ram.
module set_assoc_cache_timing_model #(
  parameter int unsigned MAX_SETS = 1024,
  parameter int unsigned WAYS     = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,   // [31:0] address
  input  logic                        s_axis_tuser,   // [0] cmd
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,   // [0] hit, [1] dirty_evicted,
                                                      // [17:2] access_cycles, rest zero
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sacm_pkg::APB_AW-1:0] paddr,
  input  logic [sacm_pkg::APB_DW-1:0] pwdata,
  output logic [sacm_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned RK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned IDX_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned ROW_W = WAYS * (2 + sacm_pkg::TAG_W + RK_W);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_CALC
  } state_e;

  state_e                      state_q, state_d;
  logic [IDX_W-1:0]            clr_cnt_q, clr_cnt_d;
  logic [sacm_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic                        cmd_q, cmd_d;
  logic                        out_valid_q, out_valid_d;
  sacm_pkg::res_t              out_q, out_d;

  sacm_pkg::cfg_t              cfg;
  sacm_pkg::res_t              res;
  logic [IDX_W-1:0]            set_idx;
  logic [ROW_W-1:0]            row_rd, row_upd, ram_wdata;
  logic [IDX_W-1:0]            ram_waddr;
  logic                        ram_we, in_fire, out_fire, calc_go;

  sacm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sacm_lookup #(
    .MAX_SETS (MAX_SETS),
    .WAYS     (WAYS)
  ) u_lookup (
    .cfg_i  (cfg),
    .cmd_i  (cmd_q),
    .addr_i (addr_q),
    .row_i  (row_rd),
    .set_o  (set_idx),
    .row_o  (row_upd),
    .res_o  (res)
  );

  sacm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (set_idx),
    .rdata_o (row_rd)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_fire      = out_valid_q & m_axis_tready;
  // hold the set row in CALC until the output register has room
  assign calc_go       = (state_q == ST_CALC) && (!out_valid_q || m_axis_tready);

  assign ram_we    = (state_q == ST_CLEAR) || calc_go;
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : set_idx;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : row_upd;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    addr_d      = addr_q;
    cmd_d       = cmd_q;
    out_valid_d = out_valid_q & ~out_fire;
    out_d       = out_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + IDX_W'(1);
        if (clr_cnt_q == IDX_W'(MAX_SETS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          addr_d  = s_axis_tdata;
          cmd_d   = s_axis_tuser;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (calc_go) begin
          out_d       = res;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
      cmd_q       <= sacm_pkg::CMD_LOAD;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      addr_q      <= addr_d;
      cmd_q       <= cmd_d;
      out_q       <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.access_cycles, out_q.dirty_evicted, out_q.hit};

`ifndef SYNTHESIS
  a_result_from_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_CALC))
    else $error("result appeared without a lookup");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  a_write_only_clear_or_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_CALC))
    else $error("tag RAM written outside clear or update");

  a_hit_never_evicts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hit) |-> !out_q.dirty_evicted)
    else $error("hit reported with a dirty eviction");

  a_pending_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_q)))
    else $error("pending result lost or changed");
`endif

endmodule

>>> bench/tb.sv
// Self-checking bench for set_assoc_cache_timing_model: directed plan, then random phases.
// Predicts hit, dirty write-back and access cost with a local copy of the tag store.
// Depends on sacm_pkg and the RTL under rtl/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SETS   = 1024;
  localparam int unsigned WAYS       = 4;
  localparam int unsigned LINES      = MAX_SETS * WAYS;
  localparam int unsigned SL_MAX     = $clog2(MAX_SETS);
  localparam int unsigned SETUPS     = 8;
  localparam int unsigned PER_SETUP  = 80;
  localparam int unsigned POOL       = 6;
  localparam int unsigned TICK_LIMIT = 200000;

  // register indexes past the end of the map; writes there must be dropped
  localparam logic [2:0] REG_SPARE = 3'd5;
  localparam logic [2:0] REG_TOP   = 3'd7;

  typedef struct packed {
    logic           is_reg;  // register write instead of an access
    logic           cmd;
    logic [31:0]    word;    // access address, or register index
    logic [31:0]    value;   // register value
    logic           typed;   // want holds a hand-written expectation
    sacm_pkg::res_t want;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] address
  logic        s_axis_tuser;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;   // [0] hit, [1] dirty_evicted, [17:2] access_cycles
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [sacm_pkg::APB_AW-1:0] paddr;
  logic [sacm_pkg::APB_DW-1:0] pwdata;
  logic [sacm_pkg::APB_DW-1:0] prdata;
  logic        pready;

  set_assoc_cache_timing_model #(
    .MAX_SETS(MAX_SETS),
    .WAYS    (WAYS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // local copy of the tag store and the registers
  logic        way_valid [LINES];
  logic        way_dirty [LINES];
  logic [29:0] way_tag   [LINES];
  logic [1:0]  way_age   [LINES];
  sacm_pkg::cfg_t cfg_q;

  sacm_pkg::res_t owed_results [$];
  plan_row_t      plan [$];
  sacm_pkg::cfg_t setups [SETUPS];
  logic [31:0]    tag_pool [POOL];
  bit             steady;
  int unsigned    errors, checked, hits_seen, dirty_seen, sent;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned ticks;
    ticks++;
    if (ticks > TICK_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, TICK_LIMIT);
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk_i) m_axis_tready <= steady || ($urandom_range(99) >= 31);

  function automatic void split_of(output int unsigned sl, output int unsigned ob);
    sl = (cfg_q.sets_log2 > SL_MAX) ? SL_MAX : cfg_q.sets_log2;
    ob = cfg_q.block_bytes_log2;
    if (ob < sacm_pkg::OB_MIN) ob = sacm_pkg::OB_MIN;
    if (ob > sacm_pkg::OB_MAX) ob = sacm_pkg::OB_MAX;
  endfunction

  // Age the other valid ways that are younger than limit, saturating at the oldest rank.
  function automatic void age_ways(int unsigned base, int unsigned skip, int unsigned limit);
    for (int unsigned j = 0; j < WAYS; j++) begin
      if (j != skip && way_valid[base+j] && way_age[base+j] < limit &&
          way_age[base+j] < WAYS - 1)
        way_age[base+j]++;
    end
  endfunction

  function automatic sacm_pkg::res_t cache_lookup(logic cmd, logic [31:0] addr);
    int unsigned    sl, ob, base, way, victim, best, cost, cyc, e;
    logic [29:0]    tag;
    bit             found;
    sacm_pkg::res_t r;
    split_of(sl, ob);
    cost  = sacm_pkg::MEM_CYCLES * (32'd1 << (ob - 2));
    base  = ((addr >> ob) & ((32'd1 << sl) - 1)) * WAYS;
    tag   = 30'(addr >> (sl + ob));
    found = 1'b0;
    cyc   = 0;
    r     = '0;
    way   = 0;
    for (int unsigned j = 0; j < WAYS && !found; j++) begin
      if (way_valid[base+j] && way_tag[base+j] == tag) begin
        found = 1'b1;
        way   = j;
      end
    end
    if (found) begin
      e     = base + way;
      r.hit = 1'b1;
      cyc   = sacm_pkg::HIT_CYCLES;
      if (cmd == sacm_pkg::CMD_STORE) begin
        if (cfg_q.write_back) way_dirty[e] = 1'b1;
        else cyc += sacm_pkg::MEM_CYCLES;
      end
      if (!cfg_q.use_fifo) begin
        age_ways(base, way, way_age[e]);
        way_age[e] = '0;
      end
    end else if (cmd == sacm_pkg::CMD_STORE && !cfg_q.write_allocate &&
                 !cfg_q.write_back) begin
      cyc = sacm_pkg::MEM_CYCLES;
    end else begin
      victim = WAYS;
      for (int unsigned j = 0; j < WAYS && victim == WAYS; j++)
        if (!way_valid[base+j]) victim = j;
      if (victim == WAYS) begin
        // all ways taken: evict the lowest-numbered way of the highest rank
        best   = 0;
        victim = 0;
        for (int unsigned j = 0; j < WAYS; j++) begin
          if (j == 0 || way_age[base+j] > best) begin
            best   = way_age[base+j];
            victim = j;
          end
        end
        if (way_dirty[base+victim]) begin
          r.dirty_evicted = 1'b1;
          cyc += cost;
        end
      end
      e    = base + victim;
      cyc += cost + sacm_pkg::HIT_CYCLES;
      age_ways(base, victim, WAYS);
      way_valid[e] = 1'b1;
      way_tag[e]   = tag;
      way_age[e]   = '0;
      way_dirty[e] = (cmd == sacm_pkg::CMD_STORE) && cfg_q.write_back;
      if (cmd == sacm_pkg::CMD_STORE && !cfg_q.write_back) cyc += sacm_pkg::MEM_CYCLES;
    end
    r.access_cycles = 16'(cyc);
    return r;
  endfunction

  function automatic void shadow_write(logic [2:0] idx, logic [31:0] v);
    case (idx)
      sacm_pkg::REG_SETS_LOG2:        cfg_q.sets_log2        = v[3:0];
      sacm_pkg::REG_BLOCK_BYTES_LOG2: cfg_q.block_bytes_log2 = v[3:0];
      sacm_pkg::REG_USE_FIFO:         cfg_q.use_fifo         = v[0];
      sacm_pkg::REG_WRITE_BACK:       cfg_q.write_back       = v[0];
      sacm_pkg::REG_WRITE_ALLOCATE:   cfg_q.write_allocate   = v[0];
      default: ;
    endcase
  endfunction

  // Mostly a small pool of tags over a few sets, so hits and evictions both happen.
  function automatic logic [31:0] pick_addr();
    int unsigned sl, ob;
    logic [31:0] set_sel;
    split_of(sl, ob);
    if ($urandom_range(99) < 15) return $urandom();
    set_sel = ($urandom_range(99) < 10) ? $urandom() : $urandom_range(3);
    return (tag_pool[$urandom_range(POOL-1)] << (sl + ob)) |
           ((set_sel & ((32'd1 << sl) - 1)) << ob) | ($urandom() & ((32'd1 << ob) - 1));
  endfunction

  function automatic logic [31:0] junk_above(logic [31:0] v, int unsigned bits);
    return ($urandom() << bits) | v;
  endfunction

  function automatic plan_row_t acc(logic cmd, logic [31:0] a);
    return '{is_reg: 1'b0, cmd: cmd, word: a, value: '0, typed: 1'b0, want: '0};
  endfunction

  function automatic plan_row_t chk(logic cmd, logic [31:0] a, logic h, logic d,
                                    logic [sacm_pkg::CYC_W-1:0] c);
    return '{is_reg: 1'b0, cmd: cmd, word: a, value: '0, typed: 1'b1,
             want: '{hit: h, dirty_evicted: d, access_cycles: c}};
  endfunction

  function automatic plan_row_t wr(logic [2:0] idx, logic [31:0] v);
    return '{is_reg: 1'b1, cmd: sacm_pkg::CMD_LOAD, word: 32'(idx), value: v,
             typed: 1'b0, want: '0};
  endfunction

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_write(idx, v);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic wait_quiet();
    s_axis_tvalid = 1'b0;
    while (owed_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic push_access(logic cmd, logic [31:0] addr, logic typed,
                             sacm_pkg::res_t want);
    sacm_pkg::res_t guess;
    while (!steady && $urandom_range(99) < 31) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = addr;
    s_axis_tuser  = cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    guess = cache_lookup(cmd, addr);
    owed_results.push_back(typed ? want : guess);
    sent++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : watch_results
    sacm_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = owed_results.pop_front();
        checked++;
        hits_seen  += m_axis_tdata[0];
        dirty_seen += m_axis_tdata[1];
        if (m_axis_tdata[0] !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[1] !== want.dirty_evicted) begin
          $display("%0t: dirty_evicted expected %0b actual %0b", $time,
                   want.dirty_evicted, m_axis_tdata[1]);
          errors++;
        end
        if (m_axis_tdata[17:2] !== want.access_cycles) begin
          $display("%0t: access_cycles expected %0d actual %0d", $time,
                   want.access_cycles, m_axis_tdata[17:2]);
          errors++;
        end
        if (m_axis_tdata[23:18] !== '0) begin
          $display("%0t: padding expected 0 actual %h", $time, m_axis_tdata[23:18]);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t row;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = sacm_pkg::CMD_LOAD;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    steady        = 1'b0;
    cfg_q         = '{sets_log2: 4'd0, block_bytes_log2: 4'd2, use_fifo: 1'b0,
                      write_back: 1'b1, write_allocate: 1'b1};
    for (int unsigned i = 0; i < LINES; i++) begin
      way_valid[i] = 1'b0;
      way_dirty[i] = 1'b0;
      way_tag[i]   = '0;
      way_age[i]   = '0;
    end

    // one set of four one-word ways after reset: every miss fetches one block, a dirty victim one more
    plan.push_back(chk(sacm_pkg::CMD_LOAD,  32'h0000_0000, 1'b0, 1'b0, 16'd101));
    plan.push_back(chk(sacm_pkg::CMD_LOAD,  32'h0000_0003, 1'b1, 1'b0, 16'd1));
    plan.push_back(chk(sacm_pkg::CMD_STORE, 32'h0000_0000, 1'b1, 1'b0, 16'd1));
    plan.push_back(chk(sacm_pkg::CMD_LOAD,  32'hFFFF_FFFF, 1'b0, 1'b0, 16'd101));
    plan.push_back(chk(sacm_pkg::CMD_STORE, 32'h0000_0010, 1'b0, 1'b0, 16'd101));
    plan.push_back(chk(sacm_pkg::CMD_LOAD,  32'h0000_0020, 1'b0, 1'b0, 16'd101));
    plan.push_back(chk(sacm_pkg::CMD_LOAD,  32'h0000_0030, 1'b0, 1'b1, 16'd201));
    plan.push_back(acc(sacm_pkg::CMD_LOAD,  32'h0000_0010));
    // write-through, no allocate
    plan.push_back(wr(sacm_pkg::REG_WRITE_BACK, 32'd0));
    plan.push_back(wr(sacm_pkg::REG_WRITE_ALLOCATE, 32'd0));
    plan.push_back(chk(sacm_pkg::CMD_STORE, 32'h0000_0040, 1'b0, 1'b0, 16'd100));
    plan.push_back(chk(sacm_pkg::CMD_STORE, 32'h0000_0010, 1'b1, 1'b0, 16'd101));
    plan.push_back(acc(sacm_pkg::CMD_LOAD,  32'h0000_0050));
    // write-back without allocate still allocates
    plan.push_back(wr(sacm_pkg::REG_WRITE_BACK, 32'd1));
    plan.push_back(acc(sacm_pkg::CMD_STORE, 32'h0000_0060));
    plan.push_back(acc(sacm_pkg::CMD_STORE, 32'h0000_0070));
    // dirty victims after a switch to write-through
    plan.push_back(wr(sacm_pkg::REG_WRITE_BACK, 32'd0));
    plan.push_back(acc(sacm_pkg::CMD_LOAD,  32'h0000_0080));
    plan.push_back(acc(sacm_pkg::CMD_LOAD,  32'h0000_0090));
    plan.push_back(acc(sacm_pkg::CMD_LOAD,  32'h0000_00A0));
    plan.push_back(wr(REG_SPARE, 32'd1));
    plan.push_back(wr(REG_TOP, 32'hFFFF_FFFF));
    plan.push_back(wr(sacm_pkg::REG_USE_FIFO, 32'd1));
    plan.push_back(wr(sacm_pkg::REG_WRITE_BACK, 32'd1));
    plan.push_back(wr(sacm_pkg::REG_WRITE_ALLOCATE, 32'd1));
    plan.push_back(acc(sacm_pkg::CMD_LOAD,  32'h0000_0100));
    plan.push_back(acc(sacm_pkg::CMD_LOAD,  32'h0000_0110));
    plan.push_back(acc(sacm_pkg::CMD_LOAD,  32'h0000_0120));
    plan.push_back(acc(sacm_pkg::CMD_LOAD,  32'h0000_0130));
    plan.push_back(acc(sacm_pkg::CMD_LOAD,  32'h0000_0100));
    // out-of-range sizes saturate
    plan.push_back(wr(sacm_pkg::REG_SETS_LOG2, 32'd15));
    plan.push_back(wr(sacm_pkg::REG_BLOCK_BYTES_LOG2, 32'd0));
    plan.push_back(acc(sacm_pkg::CMD_LOAD,  32'h0000_0FFC));
    plan.push_back(acc(sacm_pkg::CMD_LOAD,  32'hFFFF_FFFC));
    plan.push_back(wr(sacm_pkg::REG_BLOCK_BYTES_LOG2, 32'd15));
    plan.push_back(wr(sacm_pkg::REG_SETS_LOG2, 32'd10));
    plan.push_back(acc(sacm_pkg::CMD_STORE, 32'h1234_5678));
    plan.push_back(acc(sacm_pkg::CMD_STORE, 32'h1234_5400));

    setups[0] = '{4'd2,  4'd4,  1'b1, 1'b1, 1'b1};
    setups[1] = '{4'd1,  4'd3,  1'b0, 1'b0, 1'b0};
    setups[2] = '{4'd15, 4'd15, 1'b0, 1'b1, 1'b0};
    setups[3] = '{4'd10, 4'd0,  1'b1, 1'b0, 1'b1};
    setups[4] = '{4'd0,  4'd10, 1'b0, 1'b1, 1'b1};
    setups[5] = '{4'd3,  4'd2,  1'b1, 1'b1, 1'b0};
    setups[6] = '{4'd5,  4'd6,  1'b0, 1'b0, 1'b1};
    setups[7] = '{4'd1,  4'd2,  1'b1, 1'b0, 1'b0};

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_reg) begin
        wait_quiet();
        apb_write(row.word[2:0], row.value);
      end else begin
        push_access(row.cmd, row.word, row.typed, row.want);
      end
    end

    for (int unsigned p = 0; p < SETUPS; p++) begin
      wait_quiet();
      apb_write(sacm_pkg::REG_SETS_LOG2, junk_above(32'(setups[p].sets_log2), 4));
      apb_write(sacm_pkg::REG_BLOCK_BYTES_LOG2,
                junk_above(32'(setups[p].block_bytes_log2), 4));
      apb_write(sacm_pkg::REG_USE_FIFO, junk_above(32'(setups[p].use_fifo), 1));
      apb_write(sacm_pkg::REG_WRITE_BACK, junk_above(32'(setups[p].write_back), 1));
      apb_write(sacm_pkg::REG_WRITE_ALLOCATE,
                junk_above(32'(setups[p].write_allocate), 1));
      for (int unsigned k = 0; k < POOL; k++) tag_pool[k] = $urandom();
      steady = (p == 0);
      for (int unsigned n = 0; n < PER_SETUP; n++)
        push_access(($urandom_range(99) < 40) ? sacm_pkg::CMD_STORE : sacm_pkg::CMD_LOAD,
                    pick_addr(), 1'b0, '0);
      steady = 1'b0;
    end

    wait_quiet();
    // leave room for any stray beat to show up
    repeat (8) @(negedge clk_i);

    $display("Sent %0d accesses over %0d register setups; %0d results checked.",
             sent, SETUPS + 1, checked);
    $display("Seen %0d hits and %0d dirty write-backs; %0d mismatches.",
             hits_seen, dirty_seen, errors);
    if (errors == 0 && owed_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sacm_pkg.sv
rtl/core/sacm_ram.sv
rtl/core/sacm_cfg.sv
rtl/core/sacm_lookup.sv
rtl/core/set_assoc_cache_timing_model.sv
bench/tb.sv
